// File: rtl/core/assert_macros.svh
// assertion macros shared by the url percent decoder rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define UPD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define UPD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/upd_pkg.sv
// types, character constants and the hex digit helper of the url percent decoder
// no dependencies; used by upd_decode, upd_out_fifo and url_percent_decoder_top
package upd_pkg;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_CR      = 8'h0D;

  // output buffer geometry
  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = 2;
  localparam int CNT_W     = 3;
  localparam logic [CNT_W-1:0] CNT_ROOM_MAX = CNT_W'(OUT_DEPTH - 2);
  localparam logic [CNT_W-1:0] CNT_FULL     = CNT_W'(OUT_DEPTH);

  // position inside a percent triplet
  typedef enum logic [2:0] {
    PH_OUTSIDE = 3'b001,
    PH_FIRST   = 3'b010,
    PH_SECOND  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       term;
    logic       last;
  } res_t;

  // zero to two result beats produced by one decoded byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             room;
  } fifo_stat_t;

  // bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      return {1'b0, t[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      return {1'b0, t[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      return {1'b0, t[3:0]};
    end
    return 5'h10;
  endfunction

endpackage

// File: rtl/core/upd_decode.sv
// escape state and combinational decode of one byte into zero to two result beats
// depends on upd_pkg
module upd_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [7:0]         byte_in,
  input  logic               plus_as_space,
  output upd_pkg::push_t     push
);

  upd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      hex_r, hex_nxt;
  logic            open_r, open_nxt;

  logic [4:0] digit;
  logic       is_hex;
  logic [7:0] hex_grow;
  logic       open_grow;

  always_comb begin
    digit     = upd_pkg::hex_digit(byte_in);
    is_hex    = !digit[4];
    open_grow = open_r && is_hex;
    hex_grow  = open_grow ? {hex_r[3:0], digit[3:0]} : hex_r;

    phase_nxt = phase_r;
    hex_nxt   = hex_r;
    open_nxt  = open_r;
    push      = '0;

    if (fire) begin
      if (byte_in == upd_pkg::CH_NUL) begin
        // flush a partial triplet before the terminator
        if (phase_r != upd_pkg::PH_OUTSIDE && hex_r != upd_pkg::CH_CR) begin
          push.r0.data = hex_r;
          push.r1.term = 1'b1;
          push.cnt     = 2'd2;
        end else begin
          push.r0.term = 1'b1;
          push.cnt     = 2'd1;
        end
        phase_nxt = upd_pkg::PH_OUTSIDE;
        hex_nxt   = 8'h00;
        open_nxt  = 1'b0;
      end else if (phase_r != upd_pkg::PH_OUTSIDE) begin
        if (phase_r == upd_pkg::PH_FIRST) begin
          phase_nxt = upd_pkg::PH_SECOND;
          hex_nxt   = hex_grow;
          open_nxt  = open_grow;
        end else begin
          if (hex_grow != upd_pkg::CH_CR) begin
            push.r0.data = hex_grow;
            push.cnt     = 2'd1;
          end
          phase_nxt = upd_pkg::PH_OUTSIDE;
          hex_nxt   = 8'h00;
          open_nxt  = 1'b0;
        end
      end else if (byte_in == upd_pkg::CH_PERCENT) begin
        phase_nxt = upd_pkg::PH_FIRST;
        hex_nxt   = 8'h00;
        open_nxt  = 1'b1;
      end else if (byte_in == upd_pkg::CH_PLUS && plus_as_space) begin
        push.r0.data = upd_pkg::CH_SPACE;
        push.cnt     = 2'd1;
      end else begin
        push.r0.data = byte_in;
        push.cnt     = 2'd1;
      end
      push.r0.last = (push.cnt == 2'd1);
      push.r1.last = (push.cnt == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= upd_pkg::PH_OUTSIDE;
      hex_r   <= 8'h00;
      open_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hex_r   <= hex_nxt;
      open_r  <= open_nxt;
    end
  end

endmodule

// File: rtl/core/upd_out_fifo.sv
// four-beat result buffer taking up to two beats per cycle and giving one on each pop
// depends on upd_pkg
module upd_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  upd_pkg::push_t       push,
  input  logic                 pop,
  output upd_pkg::res_t        head,
  output logic                 not_empty,
  output upd_pkg::fifo_stat_t  stat
);

  upd_pkg::res_t mem_r [upd_pkg::OUT_DEPTH];

  logic [upd_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [upd_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [upd_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [upd_pkg::PTR_W-1:0] wr_ptr_p1;

  always_comb begin
    wr_ptr_p1  = wr_ptr_r + 1'b1;
    wr_ptr_nxt = wr_ptr_r + push.cnt;
    rd_ptr_nxt = rd_ptr_r + {{(upd_pkg::PTR_W-1){1'b0}}, pop};
    count_nxt  = count_r + upd_pkg::CNT_W'(push.cnt)
               - {{(upd_pkg::CNT_W-1){1'b0}}, pop};
    head       = mem_r[rd_ptr_r];
    not_empty  = (count_r != '0);
    stat.count = count_r;
    stat.room  = (count_r <= upd_pkg::CNT_ROOM_MAX);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/core/url_percent_decoder_top.sv
// top level of the url percent decoder: input register, decode, result buffer
// depends on upd_pkg, upd_decode, upd_out_fifo and assert_macros.svh
//
//  channel | direction | handshake          | payload
//  in_     | sink      | in_valid/in_stall   | in_byte
//  out_    | source    | out_valid/out_stall | out_byte, out_is_terminator, out_last_of_run
//  cfg_    | sink      | cfg_valid/cfg_ready | cfg_data (plus_as_space)
//
// one byte accepted per cycle while in_stall is low; it is held in the input register, then decoded into the buffer
// a zero byte that closes an open triplet gives two beats unless the partial value is a carriage return, else one
// the four-beat result buffer sets the rate: input stalls when under two slots are free
// synchronous active-low reset clears the escape state, buffer and sets plus_as_space
// cfg_ready is always high; out_stall reaches in_stall only through the buffer fill
`include "assert_macros.svh"

module url_percent_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_terminator,
  output logic       out_last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic       stage_valid_r, stage_valid_nxt;
  logic [7:0] stage_byte_r;
  logic       plus_as_space_r;
  logic       in_accept;
  logic       fire;
  logic       pop;

  upd_pkg::push_t      push;
  upd_pkg::res_t       head;
  upd_pkg::fifo_stat_t stat;

  always_comb begin
    fire      = stage_valid_r && stat.room;
    in_stall  = stage_valid_r && !fire;
    in_accept = in_valid && !in_stall;
    pop       = out_valid && !out_stall;
    cfg_ready = 1'b1;
    stage_valid_nxt = in_accept ? 1'b1 : (fire ? 1'b0 : stage_valid_r);
    out_byte          = head.data;
    out_is_terminator = head.term;
    out_last_of_run   = head.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r   <= 1'b0;
      plus_as_space_r <= 1'b1;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        plus_as_space_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_byte_r <= in_byte;
    end
  end

  upd_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .byte_in       (stage_byte_r),
    .plus_as_space (plus_as_space_r),
    .push          (push)
  );

  upd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .stat      (stat)
  );

  // buffer fill never passes its depth
  `UPD_ASSERT(a_fill_bound, clk, rst_n, stat.count <= upd_pkg::CNT_FULL, "result buffer overfilled")
  // a decode with no room for two beats would overrun the buffer
  `UPD_ASSERT_NEVER(a_fire_room, clk, rst_n, fire && (stat.count > upd_pkg::CNT_ROOM_MAX), "decode without room")
  // every terminator beat closes the run of its byte
  `UPD_ASSERT(a_term_last, clk, rst_n, !(out_valid && out_is_terminator) || out_last_of_run, "terminator not last")
  // a held byte stays put until it is decoded
  `UPD_ASSERT(a_stage_hold, clk, rst_n, (stage_valid_r && !fire) |=> (stage_valid_r && $stable(stage_byte_r)), "staged byte lost")

endmodule

// File: verif/upd_decode_check.sv
// decode checker for the url percent decoder: tracks escape state and plus_as_space,
// predicts result beats per accepted byte and compares them with the output channel
// depends on upd_pkg
`timescale 1ns / 1ps

module upd_decode_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_is_terminator,
  input  logic       out_last_of_run,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_data,
  output int         mismatches,
  output int         pending,
  output int         beats_checked,
  output int         terms_checked
);

  localparam int NOT_HEX = 16;

  upd_pkg::phase_t esc_phase;
  logic [7:0]      hex_acc;
  logic            run_open;
  logic            plus_sp;
  upd_pkg::res_t   decoded_q[$];

  initial begin
    mismatches    = 0;
    pending       = 0;
    beats_checked = 0;
    terms_checked = 0;
  end

  function automatic int digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return NOT_HEX;
  endfunction

  function automatic void clear_escape();
    esc_phase = upd_pkg::PH_OUTSIDE;
    hex_acc   = 8'h00;
    run_open  = 1'b0;
  endfunction

  // zero, one or two beats per byte; the final one carries last_of_run
  function automatic void decode_byte(input logic [7:0] c);
    upd_pkg::res_t r [2];
    int            n;
    int            dv;
    n = 0;
    if (c == upd_pkg::CH_NUL) begin
      if (esc_phase != upd_pkg::PH_OUTSIDE && hex_acc != upd_pkg::CH_CR) begin
        r[n] = '{hex_acc, 1'b0, 1'b0};
        n++;
      end
      r[n] = '{8'h00, 1'b1, 1'b0};
      n++;
      clear_escape();
    end else if (esc_phase != upd_pkg::PH_OUTSIDE) begin
      dv = digit_value(c);
      if (run_open && dv < NOT_HEX) hex_acc = {hex_acc[3:0], 4'(dv)};
      else run_open = 1'b0;
      if (esc_phase == upd_pkg::PH_FIRST) begin
        esc_phase = upd_pkg::PH_SECOND;
      end else begin
        // an escaped carriage return is swallowed
        if (hex_acc != upd_pkg::CH_CR) begin
          r[n] = '{hex_acc, 1'b0, 1'b0};
          n++;
        end
        clear_escape();
      end
    end else if (c == upd_pkg::CH_PERCENT) begin
      esc_phase = upd_pkg::PH_FIRST;
      hex_acc   = 8'h00;
      run_open  = 1'b1;
    end else if (c == upd_pkg::CH_PLUS && plus_sp) begin
      r[n] = '{upd_pkg::CH_SPACE, 1'b0, 1'b0};
      n++;
    end else begin
      r[n] = '{c, 1'b0, 1'b0};
      n++;
    end
    if (n > 0) r[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) decoded_q.push_back(r[i]);
  endfunction

  always @(posedge clk) begin
    upd_pkg::res_t want;
    if (!rst_n) begin
      clear_escape();
      plus_sp = 1'b1;
      decoded_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected beat byte %h term %b last %b", $time,
                     out_byte, out_is_terminator, out_last_of_run);
        end else begin
          want = decoded_q.pop_front();
          beats_checked++;
          if (want.term) terms_checked++;
          if (out_byte !== want.data || out_is_terminator !== want.term ||
              out_last_of_run !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: beat mismatch, expected byte %h term %b last %b,",
                        " got byte %h term %b last %b"},
                       $time, want.data, want.term, want.last,
                       out_byte, out_is_terminator, out_last_of_run);
          end
        end
      end
      if (in_valid && !in_stall) decode_byte(in_byte);
      if (cfg_valid && cfg_ready) plus_sp = cfg_data;
    end
    pending <= decoded_q.size();
  end

endmodule

// File: verif/url_percent_decoder_top_tb.sv
// testbench top for url_percent_decoder_top: clock, reset, byte stimulus, stalls
// and plus_as_space writes; depends on upd_pkg, the rtl and upd_decode_check
`timescale 1ns / 1ps

module url_percent_decoder_top_tb;

  localparam int ITEMS_RANDOM = 1500;
  localparam int PHASES       = 6;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 6;
  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef logic [7:0] byte_list_t[$];

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_data  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_is_terminator;
  logic       out_last_of_run;
  logic       cfg_ready;

  int mismatches, pending, beats_checked, terms_checked;
  int bytes_sent  = 0;
  int cfg_writes  = 0;
  int holds_asked = 0;
  int holds_done  = 0;
  bit tx_steady   = 1'b0;

  always #5 clk = ~clk;

  url_percent_decoder_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_is_terminator (out_is_terminator),
    .out_last_of_run   (out_last_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  upd_decode_check u_decode_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_is_terminator (out_is_terminator),
    .out_last_of_run   (out_last_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .pending           (pending),
    .beats_checked     (beats_checked),
    .terms_checked     (terms_checked)
  );

  function automatic int tx_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] hex_char(input int unsigned v);
    if (v < 10) return CH_DIGIT0 + 8'(v);
    return ($urandom_range(0, 1) != 0 ? CH_UPPER_A : CH_LOWER_A) + 8'(v - 10);
  endfunction

  // any byte but zero that may turn up inside a triplet
  function automatic logic [7:0] odd_char();
    case ($urandom_range(0, 3))
      0: return hex_char($urandom_range(0, 15));
      1: return upd_pkg::CH_PLUS;
      2: return upd_pkg::CH_PERCENT;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_list(input byte_list_t bytes_in);
    foreach (bytes_in[i]) send_byte(bytes_in[i]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_plus_mode(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic send_triplet(input logic [7:0] value);
    send_byte(upd_pkg::CH_PERCENT);
    send_byte(hex_char(value[7:4]));
    send_byte(hex_char(value[3:0]));
  endtask

  // well-formed string: plain bytes, plus signs and complete escapes
  task automatic send_clean_string();
    int         r;
    logic [7:0] c;
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        c = 8'($urandom_range(1, 255));
        if (c == upd_pkg::CH_PERCENT) c = upd_pkg::CH_PLUS;
        send_byte(c);
      end else if (r < 60) begin
        send_byte(upd_pkg::CH_PLUS);
      end else if (r < 65) begin
        send_triplet(upd_pkg::CH_CR);
      end else begin
        send_triplet(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 4) != 0) send_byte(upd_pkg::CH_NUL);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      1: begin
        send_byte(upd_pkg::CH_PERCENT);
        repeat (2) send_byte(odd_char());
      end
      2: begin
        // string ends inside a triplet
        send_byte(upd_pkg::CH_PERCENT);
        if ($urandom_range(0, 1) != 0) send_byte(odd_char());
        send_byte(upd_pkg::CH_NUL);
      end
      default: begin
        send_byte(upd_pkg::CH_PERCENT);
        send_byte(hex_char(upd_pkg::CH_CR[3:0]));
        send_byte(upd_pkg::CH_NUL);
      end
    endcase
  endtask

  // receiver: random stalls, quiet stretches and the requested long hold-offs
  initial begin : rx_side
    int stall_left;
    int r;
    bit rx_steady;
    stall_left = 0;
    rx_steady  = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) == 0) rx_steady = !rx_steady;
      if (holds_done < holds_asked) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_steady) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) stall_left = $urandom_range(1, 3);
        else if (r < 17) stall_left = $urandom_range(10, 40);
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("url_percent_decoder_top_tb: done, errors");
    $finish;
  end

  initial begin
    int target;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plain bytes, plus, escapes in both cases, escaped cr, non-hex and
    // plus or percent inside a triplet, zero inside a triplet, bare zero
    send_list('{8'h41, 8'hFF, upd_pkg::CH_PLUS,
                upd_pkg::CH_PERCENT, 8'h34, 8'h31,
                upd_pkg::CH_PERCENT, 8'h66, 8'h46,
                upd_pkg::CH_PERCENT, 8'h30, 8'h64,
                upd_pkg::CH_PERCENT, 8'h47, 8'h31,
                upd_pkg::CH_PERCENT, upd_pkg::CH_PLUS, upd_pkg::CH_PERCENT,
                upd_pkg::CH_PERCENT, 8'h37, upd_pkg::CH_NUL,
                upd_pkg::CH_PERCENT, upd_pkg::CH_NUL,
                upd_pkg::CH_NUL,
                upd_pkg::CH_PERCENT, 8'h34});
    // register change while a triplet is open
    settle();
    write_plus_mode(1'b0);
    send_list('{8'h31, upd_pkg::CH_PLUS, 8'h01});
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_plus_mode(ph == 0 ? 1'b1 : ph == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
      if (ph == 1 || ph == 4) begin
        holds_asked++;
        tx_steady = 1'b1;
      end
      target = bytes_sent + ITEMS_RANDOM / PHASES;
      while (bytes_sent < target) begin
        if ($urandom_range(0, 9) < 7) send_clean_string();
        else send_noise();
        if ($urandom_range(0, 7) == 0) tx_steady = !tx_steady;
      end
      settle();
    end

    $display("drove %0d bytes, checked %0d result beats of which %0d were string ends",
             bytes_sent, beats_checked, terms_checked);
    $display("%0d plus_as_space writes, %0d long receiver hold-offs, %0d mismatches",
             cfg_writes, holds_done, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("url_percent_decoder_top_tb: done, clean");
    end else begin
      $display("url_percent_decoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule
